@@ hdl/pf_pkg.sv @@
// Shared types and constants for the Playfair digraph cipher unit.
// Depends on nothing; every other file imports it.
package pf_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = SIDE * SIDE;

    localparam logic [4:0] JUNK_RESET = 5'd23;

    // Register indexes on the configuration port (byte address is 8 * index).
    localparam logic [2:0] REG_SQUARE_A = 3'd0;
    localparam logic [2:0] REG_SQUARE_B = 3'd1;
    localparam logic [2:0] REG_SQUARE_C = 3'd2;
    localparam logic [2:0] REG_JUNK     = 3'd3;
    localparam logic [2:0] REG_DECODE   = 3'd4;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] coord_t;

    // Cell k of the square, row-major.
    typedef letter_t [CELLS-1:0] square_t;

    typedef struct packed {
        letter_t letter_in;
        logic    text_end;
    } text_beat_t;

    typedef struct packed {
        letter_t letter_out;
        logic    run_last;
        logic    not_in_square;
    } code_beat_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    miss;
    } pair_result_t;

endpackage

@@ hdl/pf_pair_lookup.sv @@
// Combinational digraph substitution: locates both letters in the square and
// applies the column, row or rectangle rule. Depends on pf_pkg.
module pf_pair_lookup
    import pf_pkg::*;
(
    input  square_t      square,
    input  logic         decode_mode,
    input  letter_t      letter_a,
    input  letter_t      letter_b,
    output pair_result_t result
);

    logic   found_a;
    logic   found_b;
    coord_t row_a;
    coord_t col_a;
    coord_t row_b;
    coord_t col_b;
    coord_t new_row_a;
    coord_t new_col_a;
    coord_t new_row_b;
    coord_t new_col_b;
    logic [4:0] cell_a;
    logic [4:0] cell_b;

    function automatic coord_t step_wrap(input coord_t v, input logic backward);
        coord_t r;
        if (backward)
        begin
            r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end
        else
        begin
            r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

    // Scanning from the top down leaves the lowest matching cell in place.
    always_comb
    begin
        found_a = 1'b0;
        found_b = 1'b0;
        row_a   = '0;
        col_a   = '0;
        row_b   = '0;
        col_b   = '0;
        for (int k = CELLS - 1; k >= 0; k--)
        begin
            if (square[k] == letter_a)
            begin
                found_a = 1'b1;
                row_a   = 3'(k / SIDE);
                col_a   = 3'(k % SIDE);
            end
            if (square[k] == letter_b)
            begin
                found_b = 1'b1;
                row_b   = 3'(k / SIDE);
                col_b   = 3'(k % SIDE);
            end
        end
    end

    always_comb
    begin
        new_row_a = row_a;
        new_col_a = col_b;
        new_row_b = row_b;
        new_col_b = col_a;
        if (col_a == col_b)
        begin
            new_row_a = step_wrap(row_a, decode_mode);
            new_row_b = step_wrap(row_b, decode_mode);
            new_col_a = col_a;
            new_col_b = col_b;
        end
        else if (row_a == row_b)
        begin
            new_col_a = step_wrap(col_a, decode_mode);
            new_col_b = step_wrap(col_b, decode_mode);
        end
    end

    // Row times five as a shift and an add; coordinates stay below five.
    assign cell_a = {new_row_a[2:0], 2'b00} + {2'b00, new_row_a} + {2'b00, new_col_a};
    assign cell_b = {new_row_b[2:0], 2'b00} + {2'b00, new_row_b} + {2'b00, new_col_b};

    always_comb
    begin
        if (found_a && found_b)
        begin
            result.first  = square[cell_a];
            result.second = square[cell_b];
            result.miss   = 1'b0;
        end
        else
        begin
            result.first  = letter_a;
            result.second = letter_b;
            result.miss   = 1'b1;
        end
    end

endmodule

@@ hdl/playfair_digraph_cipher_unit.sv @@
// Playfair digraph cipher unit, built on pf_pkg and pf_pair_lookup.
// A pair is registered in the pair stage, then substituted into the result stage, which
// gives one result beat per cycle while code_ready is high. A letter is taken only while
// the pair stage is empty or moves on. A pair gives two beats, a doubled pair four, a
// held letter none. Reset (rst_n low, asynchronous) empties both stages, drops the held
// letter, zeroes the square, sets junk to x and selects encoding.
module playfair_digraph_cipher_unit
    import pf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        text_valid,
    output logic        text_ready,
    input  text_beat_t  text_data,

    output logic        code_valid,
    input  logic        code_ready,
    output code_beat_t  code_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [49:0] square_a_reg;
    logic [49:0] square_b_reg;
    logic [24:0] square_c_reg;
    letter_t     junk_reg;
    logic        decode_reg;

    letter_t     held_reg;
    logic        holding_reg;

    logic        pair_valid_reg;
    letter_t     pair_a_reg;
    letter_t     pair_b_reg;
    logic        pair_dbl_reg;

    logic        res_valid_reg;
    letter_t     res_a_reg;
    letter_t     res_b_reg;
    logic        res_miss_reg;
    logic        res_dbl_reg;
    logic [1:0]  beat_reg;

    logic         text_fire;
    logic         code_fire;
    logic         last_beat;
    logic         res_free;
    logic         pair_move;
    logic         makes_pair;
    letter_t      pair_a_next;
    letter_t      pair_b_next;
    logic         pair_dbl_next;
    logic         holding_next;
    logic [2:0]   reg_index;
    logic         cfg_write;
    square_t      square;
    pair_result_t lookup;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_a_reg <= '0;
            square_b_reg <= '0;
            square_c_reg <= '0;
            junk_reg     <= JUNK_RESET;
            decode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SQUARE_A: square_a_reg <= pwdata[49:0];
                REG_SQUARE_B: square_b_reg <= pwdata[49:0];
                REG_SQUARE_C: square_c_reg <= pwdata[24:0];
                REG_JUNK:     junk_reg     <= pwdata[4:0];
                REG_DECODE:   decode_reg   <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SQUARE_A: prdata = {14'd0, square_a_reg};
            REG_SQUARE_B: prdata = {14'd0, square_b_reg};
            REG_SQUARE_C: prdata = {39'd0, square_c_reg};
            REG_JUNK:     prdata = {59'd0, junk_reg};
            REG_DECODE:   prdata = {63'd0, decode_reg};
            default:      prdata = '0;
        endcase
    end

    assign square = {square_c_reg, square_b_reg, square_a_reg};

    // ---------------- handshake ----------------
    assign last_beat  = res_dbl_reg ? (beat_reg == 2'd3) : (beat_reg == 2'd1);
    assign code_valid = res_valid_reg;
    assign code_fire  = code_valid && code_ready;
    assign res_free   = !res_valid_reg || (code_fire && last_beat);
    assign pair_move  = pair_valid_reg && res_free;
    assign text_ready = !pair_valid_reg || res_free;
    assign text_fire  = text_valid && text_ready;

    assign code_data.letter_out    = beat_reg[0] ? res_b_reg : res_a_reg;
    assign code_data.run_last      = last_beat;
    assign code_data.not_in_square = res_miss_reg;

    // ---------------- pairing ----------------
    always_comb
    begin
        makes_pair    = 1'b1;
        pair_a_next   = held_reg;
        pair_b_next   = text_data.letter_in;
        pair_dbl_next = 1'b0;
        holding_next  = 1'b0;
        if (!holding_reg)
        begin
            pair_a_next = text_data.letter_in;
            pair_b_next = junk_reg;
            if (!text_data.text_end)
            begin
                makes_pair   = 1'b0;
                holding_next = 1'b1;
            end
        end
        else if (text_data.letter_in == held_reg)
        begin
            // A doubled letter is sent as the same padded pair twice.
            pair_b_next   = junk_reg;
            pair_dbl_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            holding_reg <= 1'b0;
        end
        else if (text_fire)
        begin
            holding_reg <= holding_next;
            if (!holding_reg)
            begin
                held_reg <= text_data.letter_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
        end
        else if (text_fire && makes_pair)
        begin
            pair_valid_reg <= 1'b1;
        end
        else if (pair_move)
        begin
            pair_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_fire && makes_pair)
        begin
            pair_a_reg   <= pair_a_next;
            pair_b_reg   <= pair_b_next;
            pair_dbl_reg <= pair_dbl_next;
        end
    end

    // ---------------- substitution ----------------
    pf_pair_lookup u_lookup (
        .square      (square),
        .decode_mode (decode_reg),
        .letter_a    (pair_a_reg),
        .letter_b    (pair_b_reg),
        .result      (lookup)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else if (pair_move)
        begin
            res_valid_reg <= 1'b1;
            beat_reg      <= '0;
        end
        else if (code_fire)
        begin
            if (last_beat)
            begin
                res_valid_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_move)
        begin
            res_a_reg    <= lookup.first;
            res_b_reg    <= lookup.second;
            res_miss_reg <= lookup.miss;
            res_dbl_reg  <= pair_dbl_reg;
        end
    end

endmodule
